### design/roa_pkg.sv
// Shared types and constants for the row offset averager.
// No dependencies.
package roa_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_COLUMN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VANISH_ROW_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_SPACING       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LATERAL_OFFSET    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_ROWS         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_PX      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_EXTRA_PX    = 3'd7;

  typedef enum logic [1:0] {
    DIV_PROJ,
    DIV_REM,
    DIV_AVG
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul;
    logic     div_start;
    div_sel_t div_sel;
    logic     xb_load;
    logic     classify;
    logic     fin;
  } cmd_t;

  typedef struct packed {
    logic cy_zero;
    logic in_range;
    logic need_avg;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

### design/roa_div.sv
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// No dependencies.
module roa_div #(
  parameter int NW = 29,
  parameter int DW = 15
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt, den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DW:0]   sh, diff;

  always_comb begin
    sh       = {rem_r, quo_r[NW-1]};
    diff     = sh - {1'b0, den_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = diff[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = sh[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (start) den_r <= den;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

### design/roa_ctrl.sv
// Sequencer for the row offset averager: steps one item through the datapath.
// Depends on roa_pkg.
module roa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             last,
  input  roa_pkg::status_t sts,
  output roa_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_D1S, S_D1W, S_XB, S_RCHK, S_D2S, S_D2W,
    S_CLS, S_ACHK, S_D3S, S_D3W, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = roa_pkg::DIV_PROJ;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.mul   = 1'b1;
        state_nxt = sts.cy_zero ? S_CLS : S_D1S;
      end
      S_D1S: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_D1W;
      end
      S_D1W: if (sts.div_done) state_nxt = S_XB;
      S_XB: begin
        cmd.xb_load = 1'b1;
        state_nxt   = S_RCHK;
      end
      S_RCHK: state_nxt = sts.in_range ? S_D2S : S_CLS;
      S_D2S: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = roa_pkg::DIV_REM;
        state_nxt     = S_D2W;
      end
      S_D2W: if (sts.div_done) state_nxt = S_CLS;
      S_CLS: begin
        cmd.classify = 1'b1;
        state_nxt    = S_ACHK;
      end
      S_ACHK: state_nxt = (last && sts.need_avg) ? S_D3S : S_FIN;
      S_D3S: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = roa_pkg::DIV_AVG;
        state_nxt     = S_D3W;
      end
      S_D3W: if (sts.div_done) state_nxt = S_FIN;
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

### design/roa_dp.sv
// Datapath: configuration, projection, folding, classification, frame sums, counters.
// Depends on roa_pkg and roa_div.
module roa_dp #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [roa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [roa_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [11:0]                       in_point_x,
  input  logic [11:0]                       in_point_y,
  input  logic                              in_last_point,
  input  roa_pkg::cmd_t                     cmd,
  output roa_pkg::status_t                  sts,
  output logic                              last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [12:0]                out_delta,
  output logic                              out_projected_ok,
  output logic                              out_within_threshold,
  output logic                              out_within_row_range,
  output logic                              out_frame_done,
  output logic                              out_avg_valid,
  output logic signed [12:0]                out_avg_delta,
  output logic [10:0]                       out_used_points,
  output logic [31:0]                       out_out_range_total,
  output logic [31:0]                       out_in_tolerance_total,
  output logic [31:0]                       out_out_tolerance_total,
  output logic [31:0]                       out_points_total
);

  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int SUMW = 13 + CNTW;
  localparam int NW   = (SUMW > 29) ? SUMW : 29;
  localparam int DW   = (CNTW > 15) ? CNTW : 15;

  logic [10:0] centre_r;
  logic [13:0] vro_r;
  logic [11:0] rows_r, sp_r, thr_r, extra_r;
  logic signed [11:0] lat_r;
  logic [5:0]  hr_r;

  logic [11:0] px_r, py_r;
  logic        last_r;
  logic signed [27:0] prod_r;
  logic signed [28:0] xb_r;
  logic        in_range_r;

  logic signed [SUMW-1:0] sum_r, sum_nxt;
  logic [CNTW-1:0]        cnt_r, cnt_nxt;
  logic [31:0] orc_r, itc_r, otc_r, seen_r;

  logic signed [12:0] d_r;
  logic proj_r, thr_ok_r, rng_ok_r;

  // projection operands
  logic signed [12:0] cx;
  logic [14:0]        cy, depth;
  logic signed [28:0] prod_w;
  logic [17:0]        sp_hr;
  logic [15:0]        rb_u;
  logic signed [15:0] rb;
  logic [28:0]        xb_abs;
  logic signed [28:0] q_s;
  logic               in_range_w;

  assign cx     = $signed({1'b0, px_r}) - $signed({2'b00, centre_r});
  assign cy     = {3'b000, py_r} + {1'b0, vro_r};
  assign depth  = {3'b000, rows_r} + {1'b0, vro_r};
  assign prod_w = $signed({14'b0, depth}) * 29'(cx);
  assign sp_hr  = {6'b0, sp_r} * {12'b0, hr_r};
  assign rb_u   = sp_hr[15:0] + {5'b0, sp_r[11:1]};
  assign rb     = $signed(rb_u);
  assign xb_abs = xb_r[28] ? 29'(-xb_r) : 29'(xb_r);
  assign in_range_w = !rb[15] && (rb != 16'sd0) && (xb_abs < {13'b0, rb_u});

  // divider
  logic [NW-1:0] div_num, div_q;
  logic [DW-1:0] div_den, div_r;
  logic [27:0]   prod_abs;
  logic [SUMW-1:0] sum_abs;
  logic          div_done;

  assign prod_abs = prod_r[27] ? 28'(-prod_r) : 28'(prod_r);
  assign sum_abs  = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);

  always_comb begin
    case (cmd.div_sel)
      roa_pkg::DIV_PROJ: begin
        div_num = NW'(prod_abs);
        div_den = DW'(cy);
      end
      roa_pkg::DIV_REM: begin
        div_num = NW'(xb_abs);
        div_den = DW'(sp_r);
      end
      roa_pkg::DIV_AVG: begin
        div_num = NW'(sum_abs);
        div_den = DW'(cnt_r);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  roa_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q),
    .rem   (div_r)
  );

  assign q_s = prod_r[27] ? -$signed({1'b0, div_q[27:0]}) : $signed({1'b0, div_q[27:0]});

  // fold and classify
  logic               proj_w;
  logic signed [13:0] r_s, half_s, sp_s, fold;
  logic signed [12:0] d_w;
  logic [12:0]        ad;
  logic               thr_w, rng_w;

  assign proj_w = (cy != 15'd0) && in_range_r;
  assign half_s = $signed({3'b000, sp_r[11:1]});
  assign sp_s   = $signed({2'b00, sp_r});
  assign r_s    = xb_r[28] ? -$signed({2'b00, div_r[11:0]}) : $signed({2'b00, div_r[11:0]});

  always_comb begin
    if (r_s >= half_s)       fold = r_s - sp_s;
    else if (r_s <= -half_s) fold = r_s + sp_s;
    else                     fold = r_s;
  end

  assign d_w   = proj_w ? fold[12:0] : 13'sd0;
  assign ad    = d_w[12] ? 13'(-d_w) : 13'(d_w);
  assign thr_w = proj_w && (ad <= {1'b0, thr_r});
  assign rng_w = proj_w && ((extra_r == 12'd0) || (ad <= ({1'b0, thr_r} + {1'b0, extra_r})));

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (cmd.classify && rng_w && (32'(cnt_r) < 32'(MAX_POINTS))) begin
      sum_nxt = sum_r + SUMW'(d_w);
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.fin && last_r) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end
  end

  // average sign
  logic signed [12:0] avg_w;
  assign avg_w = sum_r[SUMW-1] ? 13'(-div_q[12:0]) : div_q[12:0];

  logic [31:0] used_w;
  assign used_w = 32'(cnt_r);

  // range flag is taken the cycle after xb is loaded
  logic sts_rchk, xb_loaded_r;
  assign sts_rchk = xb_loaded_r;
  always_ff @(posedge clk) begin
    if (!rst_n) xb_loaded_r <= 1'b0;
    else        xb_loaded_r <= cmd.xb_load;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r   <= in_point_x;
      py_r   <= in_point_y;
      last_r <= in_last_point;
    end
    if (cmd.mul) prod_r <= prod_w[27:0];
    if (cmd.xb_load) xb_r <= q_s - 29'(lat_r);
    if (cmd.classify) begin
      d_r      <= d_w;
      proj_r   <= proj_w;
      thr_ok_r <= thr_w;
      rng_ok_r <= rng_w;
    end
    if (cmd.fin) begin
      out_delta            <= d_r;
      out_projected_ok     <= proj_r;
      out_within_threshold <= thr_ok_r;
      out_within_row_range <= rng_ok_r;
      out_frame_done       <= last_r;
      out_avg_valid        <= last_r && (cnt_r != '0);
      out_avg_delta        <= (last_r && (cnt_r != '0)) ? avg_w : 13'sd0;
      out_used_points      <= used_w[10:0];
      out_out_range_total  <= orc_r;
      out_in_tolerance_total  <= itc_r;
      out_out_tolerance_total <= otc_r;
      out_points_total     <= seen_r;
    end
    if (!rst_n) begin
      centre_r   <= 11'd320;
      vro_r      <= 14'd100;
      rows_r     <= 12'd480;
      sp_r       <= 12'd100;
      lat_r      <= 12'sd0;
      hr_r       <= 6'd2;
      thr_r      <= 12'd10;
      extra_r    <= 12'd0;
      in_range_r <= 1'b0;
      sum_r      <= '0;
      cnt_r      <= '0;
      orc_r      <= '0;
      itc_r      <= '0;
      otc_r      <= '0;
      seen_r     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          roa_pkg::REG_CENTRE_COLUMN:     centre_r <= cfg_data[10:0];
          roa_pkg::REG_VANISH_ROW_OFFSET: vro_r    <= cfg_data[13:0];
          roa_pkg::REG_SCREEN_ROWS:       rows_r   <= cfg_data[11:0];
          roa_pkg::REG_ROW_SPACING:       sp_r     <= cfg_data[11:0];
          roa_pkg::REG_LATERAL_OFFSET:    lat_r    <= $signed(cfg_data[11:0]);
          roa_pkg::REG_HALF_ROWS:         hr_r     <= cfg_data[5:0];
          roa_pkg::REG_THRESHOLD_PX:      thr_r    <= cfg_data[11:0];
          roa_pkg::REG_RANGE_EXTRA_PX:    extra_r  <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (cmd.load) in_range_r <= 1'b0;
      else if (cmd.xb_load) in_range_r <= 1'b0;
      else if (sts_rchk) in_range_r <= in_range_w;
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      if (cmd.classify) begin
        seen_r <= seen_r + 32'd1;
        if (!rng_w)     orc_r <= orc_r + 32'd1;
        else if (thr_w) itc_r <= itc_r + 32'd1;
        else            otc_r <= otc_r + 32'd1;
      end
      if (cmd.fin)                     out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  assign last = last_r;

  always_comb begin
    sts          = '0;
    sts.cy_zero  = (cy == 15'd0);
    sts.in_range = in_range_w;
    sts.need_avg = (cnt_r != '0);
    sts.div_done = div_done;
    sts.out_free = !out_valid || !out_stall;
  end

endmodule

### design/row_offset_averager.sv
// Row offset averager top level: controller plus datapath.
// Depends on roa_pkg, roa_ctrl, roa_dp, roa_div.
// Items are handled one at a time: a projected in-range point takes two serial divisions of
// 29 bits on the shared divider, and a frame's last item that carries an average adds a third;
// a point out of range skips the second division, and one on the vanishing row skips both.
// A new item is taken only once the previous result has gone to the output; a stalled result holds it.
// Reset: synchronous active-low rst_n restores register defaults and clears the frame sum and point counters.
module row_offset_averager #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [roa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [roa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [11:0]                    in_point_x,
  input  logic [11:0]                    in_point_y,
  input  logic                           in_last_point,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [12:0]             out_delta,
  output logic                           out_projected_ok,
  output logic                           out_within_threshold,
  output logic                           out_within_row_range,
  output logic                           out_frame_done,
  output logic                           out_avg_valid,
  output logic signed [12:0]             out_avg_delta,
  output logic [10:0]                    out_used_points,
  output logic [31:0]                    out_out_range_total,
  output logic [31:0]                    out_in_tolerance_total,
  output logic [31:0]                    out_out_tolerance_total,
  output logic [31:0]                    out_points_total
);

  roa_pkg::cmd_t    cmd;
  roa_pkg::status_t sts;
  logic             last;

  roa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .last     (last),
    .sts      (sts),
    .cmd      (cmd)
  );

  roa_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_point_x              (in_point_x),
    .in_point_y              (in_point_y),
    .in_last_point           (in_last_point),
    .cmd                     (cmd),
    .sts                     (sts),
    .last                    (last),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_delta               (out_delta),
    .out_projected_ok        (out_projected_ok),
    .out_within_threshold    (out_within_threshold),
    .out_within_row_range    (out_within_row_range),
    .out_frame_done          (out_frame_done),
    .out_avg_valid           (out_avg_valid),
    .out_avg_delta           (out_avg_delta),
    .out_used_points         (out_used_points),
    .out_out_range_total     (out_out_range_total),
    .out_in_tolerance_total  (out_in_tolerance_total),
    .out_out_tolerance_total (out_out_tolerance_total),
    .out_points_total        (out_points_total)
  );

endmodule

### dv/row_offset_averager_chk.sv
// Checker for the row offset averager: tracks register writes, predicts each result item
// from accepted input items and compares it with what the block delivers.
// Depends on roa_pkg.
module row_offset_averager_chk #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [roa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [roa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [11:0]                    in_point_x,
  input  logic [11:0]                    in_point_y,
  input  logic                           in_last_point,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [12:0]             out_delta,
  input  logic                           out_projected_ok,
  input  logic                           out_within_threshold,
  input  logic                           out_within_row_range,
  input  logic                           out_frame_done,
  input  logic                           out_avg_valid,
  input  logic signed [12:0]             out_avg_delta,
  input  logic [10:0]                    out_used_points,
  input  logic [31:0]                    out_out_range_total,
  input  logic [31:0]                    out_in_tolerance_total,
  input  logic [31:0]                    out_out_tolerance_total,
  input  logic [31:0]                    out_points_total,
  output int                             fail_count,
  output int                             pending_rows
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [12:0] delta;
    logic               proj;
    logic               thr;
    logic               rng;
    logic               done;
    logic               avgv;
    logic signed [12:0] avg;
    logic [10:0]        used;
    logic [31:0]        orng;
    logic [31:0]        intol;
    logic [31:0]        outtol;
    logic [31:0]        seen;
  } row_result_t;

  logic [10:0]        centre_col;
  logic [13:0]        vanish_off;
  logic [11:0]        scr_rows;
  logic [11:0]        spacing;
  logic signed [11:0] lat_off;
  logic [5:0]         half_cnt;
  logic [11:0]        thresh;
  logic [11:0]        extra;

  int          frame_sum;
  int          frame_used;
  logic [31:0] orng_cnt, intol_cnt, outtol_cnt, seen_cnt;
  row_result_t expected_rows[$];

  assign pending_rows = expected_rows.size();

  function automatic row_result_t predict_row(logic [11:0] px, logic [11:0] py, logic last);
    int sp, half, depth, cx, cy, rb, xb, r, d, ad;
    bit proj, thr, rng;
    row_result_t o;
    sp    = int'(spacing);
    half  = sp / 2;
    depth = int'(vanish_off) + int'(scr_rows);
    cx    = int'(px) - int'(centre_col);
    cy    = int'(vanish_off) + int'(py);
    rb    = int'(shortint'(int'(shortint'(sp * int'(half_cnt))) + half));
    proj  = 1'b0;
    d     = 0;
    thr   = 1'b0;
    rng   = 1'b0;
    if (cy != 0) begin
      xb = (depth * cx) / cy - int'(lat_off);
      if ((xb < 0 ? -xb : xb) < rb) begin
        r = (sp == 0) ? xb : xb % sp;
        if (r >= half) r -= sp;
        else if (r <= -half) r += sp;
        d    = r;
        proj = 1'b1;
      end
    end
    seen_cnt++;
    if (proj) begin
      ad  = d < 0 ? -d : d;
      thr = ad <= int'(thresh);
      rng = (extra == 12'd0) || ad <= int'(thresh) + int'(extra);
    end
    if (!rng) begin
      orng_cnt++;
    end else begin
      if (frame_used < MAX_POINTS) begin
        frame_used++;
        frame_sum += d;
      end
      if (thr) intol_cnt++;
      else outtol_cnt++;
    end
    o.delta  = d[12:0];
    o.proj   = proj;
    o.thr    = thr;
    o.rng    = rng;
    o.done   = last;
    o.avgv   = 1'b0;
    o.avg    = '0;
    o.used   = frame_used[10:0];
    o.orng   = orng_cnt;
    o.intol  = intol_cnt;
    o.outtol = outtol_cnt;
    o.seen   = seen_cnt;
    if (last) begin
      if (frame_used > 0) begin
        o.avgv = 1'b1;
        o.avg  = 13'(frame_sum / frame_used);
      end
      frame_sum  = 0;
      frame_used = 0;
    end
    return o;
  endfunction

  always @(posedge clk) begin
    row_result_t e, a;
    if (!rst_n) begin
      centre_col = 11'd320;
      vanish_off = 14'd100;
      scr_rows   = 12'd480;
      spacing    = 12'd100;
      lat_off    = '0;
      half_cnt   = 6'd2;
      thresh     = 12'd10;
      extra      = '0;
      frame_sum  = 0;
      frame_used = 0;
      orng_cnt   = '0;
      intol_cnt  = '0;
      outtol_cnt = '0;
      seen_cnt   = '0;
      expected_rows.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          roa_pkg::REG_CENTRE_COLUMN:     centre_col = cfg_data[10:0];
          roa_pkg::REG_VANISH_ROW_OFFSET: vanish_off = cfg_data[13:0];
          roa_pkg::REG_SCREEN_ROWS:       scr_rows   = cfg_data[11:0];
          roa_pkg::REG_ROW_SPACING:       spacing    = cfg_data[11:0];
          roa_pkg::REG_LATERAL_OFFSET:    lat_off    = $signed(cfg_data[11:0]);
          roa_pkg::REG_HALF_ROWS:         half_cnt   = cfg_data[5:0];
          roa_pkg::REG_THRESHOLD_PX:      thresh     = cfg_data[11:0];
          roa_pkg::REG_RANGE_EXTRA_PX:    extra      = cfg_data[11:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_rows.push_back(predict_row(in_point_x, in_point_y, in_last_point));
      if (out_valid && !out_stall) begin
        a = '{out_delta, out_projected_ok, out_within_threshold, out_within_row_range,
              out_frame_done, out_avg_valid, out_avg_delta, out_used_points,
              out_out_range_total, out_in_tolerance_total, out_out_tolerance_total,
              out_points_total};
        if (expected_rows.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result item %p", a);
        end else begin
          e = expected_rows.pop_front();
          if (e.delta !== a.delta || e.proj !== a.proj || e.thr !== a.thr ||
              e.rng !== a.rng || e.done !== a.done || e.avgv !== a.avgv ||
              e.avg !== a.avg || e.used !== a.used || e.orng !== a.orng ||
              e.intol !== a.intol || e.outtol !== a.outtol || e.seen !== a.seen) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", e, a);
          end
        end
      end
    end
  end
endmodule

### dv/row_offset_averager_test.sv
// Testbench top for the row offset averager: clock, reset, register writes and item
// stimulus under varying idle and stall rates; verdict from the checker's counts.
// Depends on roa_pkg, row_offset_averager, row_offset_averager_chk.
module row_offset_averager_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic [roa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [roa_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [11:0]                    in_point_x = '0;
  logic [11:0]                    in_point_y = '0;
  logic                           in_last_point = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [12:0]             out_delta, out_avg_delta;
  logic                           out_projected_ok, out_within_threshold, out_within_row_range;
  logic                           out_frame_done, out_avg_valid;
  logic [10:0]                    out_used_points;
  logic [31:0]                    out_out_range_total, out_in_tolerance_total;
  logic [31:0]                    out_out_tolerance_total, out_points_total;
  int                             fail_count, pending_rows;
  int                             send_idle = 0, recv_stall = 0, quiet_cycles = 0;
  logic [10:0]                    centre_now = 11'd320;

  always #10 clk = ~clk;

  row_offset_averager u_top (.*);
  row_offset_averager_chk u_chk (.*);

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_point(input logic [11:0] x, input logic [11:0] y, input logic l);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_point_x    <= x;
    in_point_y    <= y;
    in_last_point <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rows != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [roa_pkg::CFG_IDX_W-1:0] idx, input int val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[roa_pkg::CFG_DATA_W-1:0];
    if (idx == roa_pkg::REG_CENTRE_COLUMN) centre_now = val[10:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_all(input int cc, vro, sr, sp, lat, hr, thr, ext);
    write_reg(roa_pkg::REG_CENTRE_COLUMN, cc);
    write_reg(roa_pkg::REG_VANISH_ROW_OFFSET, vro);
    write_reg(roa_pkg::REG_SCREEN_ROWS, sr);
    write_reg(roa_pkg::REG_ROW_SPACING, sp);
    write_reg(roa_pkg::REG_LATERAL_OFFSET, lat & 12'hfff);
    write_reg(roa_pkg::REG_HALF_ROWS, hr);
    write_reg(roa_pkg::REG_THRESHOLD_PX, thr);
    write_reg(roa_pkg::REG_RANGE_EXTRA_PX, ext);
  endtask

  task automatic random_cfg();
    if ($urandom_range(3) == 0)
      write_all($urandom_range(2047), $urandom_range(16383), $urandom_range(4095, 1),
                $urandom_range(4095), $urandom_range(4095), $urandom_range(63),
                $urandom_range(4095), $urandom_range(4095));
    else
      write_all($urandom_range(600, 100), $urandom_range(300), $urandom_range(800, 200),
                $urandom_range(200, 1), int'($urandom_range(200)) - 100,
                $urandom_range(8, 1), $urandom_range(40),
                $urandom_range(1) ? 0 : $urandom_range(60));
  endtask

  task automatic random_frames(input int n);
    int k, len;
    logic [11:0] x, y;
    k = 0;
    while (k < n) begin
      len = int'($urandom_range(40, 1));
      if (len > n - k) len = n - k;
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(9) < 7) begin
          x = 12'(int'(centre_now) + int'($urandom_range(400)) - 200);
          y = 12'($urandom_range(500));
        end else begin
          x = 12'($urandom);
          y = 12'($urandom);
        end
        push_point(x, y, (j == len - 1));
        k++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults, field extremes
    push_point(12'd320, 12'd0, 1'b0);
    push_point(12'd0, 12'd0, 1'b0);
    push_point(12'hfff, 12'hfff, 1'b0);
    push_point(12'd370, 12'd50, 1'b0);
    push_point(12'd400, 12'd200, 1'b1);
    push_point(12'd300, 12'd100, 1'b1);
    drain();
    // vanishing row: cy zero; negative lateral extreme, extra range on
    write_all(2047, 0, 4095, 1, -2048, 63, 0, 4095);
    push_point(12'd2047, 12'd0, 1'b0);
    push_point(12'd2000, 12'd1, 1'b0);
    push_point(12'd0, 12'd4095, 1'b1);
    drain();
    // zero spacing, half rows zero, positive lateral extreme
    write_all(0, 16383, 1, 0, 2047, 0, 4095, 1);
    push_point(12'd0, 12'd0, 1'b0);
    push_point(12'hfff, 12'hfff, 1'b1);
    drain();
    // baseline range wraps negative
    write_all(320, 100, 480, 4095, 0, 63, 10, 0);
    push_point(12'd320, 12'd50, 1'b0);
    push_point(12'd321, 12'd50, 1'b1);
    drain();
    // folding at half spacing, rejection by the extra range
    write_all(320, 100, 480, 100, 0, 5, 5, 10);
    push_point(12'd370, 12'd380, 1'b0);
    push_point(12'd270, 12'd380, 1'b0);
    push_point(12'd340, 12'd380, 1'b0);
    push_point(12'd335, 12'd380, 1'b0);
    push_point(12'd308, 12'd380, 1'b1);
    drain();

    // full frame past the point limit, no idling
    write_all(320, 100, 480, 4095, 0, 7, 2000, 0);
    for (int j = 0; j < 1030; j++)
      push_point(12'($urandom_range(4095)), 12'($urandom_range(4095)), (j == 1029));
    drain();

    random_cfg();
    random_frames(30);
    drain();
    random_cfg();
    send_idle = 84;
    random_frames(30);
    // sender holds off until everything has come back
    drain();
    random_cfg();
    send_idle = 0;
    recv_stall = 84;
    random_frames(30);
    drain();
    random_cfg();
    send_idle = 18;
    recv_stall = 18;
    random_frames(30);
    drain();
    random_cfg();
    send_idle = 0;
    recv_stall = 0;
    random_frames(30);
    drain();

    if (fail_count == 0 && pending_rows == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
